[rtl/cell_grid_pixel_renderer_core_assert.svh]
// Assertion macros shared by the cell grid pixel renderer RTL.
// Depends on nothing; included by the files that carry concurrent assertions.
`ifndef CELL_GRID_PIXEL_RENDERER_CORE_ASSERT_SVH
`define CELL_GRID_PIXEL_RENDERER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CGPR_ASSERT_SAME(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("cgpr: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CGPR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("cgpr: assertion failed");

`endif

[rtl/cgpr_pkg.sv]
// Package of the cell grid pixel renderer: transaction types, codes and colors.
// Depends on nothing; used by the core and its grid memory.
`timescale 1ns / 1ps

package cgpr_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH_PIXELS  = 3'd0,
    CFG_HEIGHT_PIXELS = 3'd1,
    CFG_MARGIN_X      = 3'd2,
    CFG_MARGIN_Y      = 3'd3,
    CFG_CELL_SIZE     = 3'd4
  } cfg_idx_e;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  typedef enum logic [1:0] {
    PIX_BLACK = 2'd0,
    PIX_LINE  = 2'd1,
    PIX_CELL  = 2'd2
  } pix_class_e;

  localparam logic [7:0] ColorLine = 8'd66;
  localparam logic [7:0] LiveRed   = 8'd49;
  localparam logic [7:0] LiveGreen = 8'd101;
  localparam logic [7:0] LiveBlue  = 8'd148;
  localparam logic [7:0] ColorDead = 8'd204;

  typedef struct packed {
    logic       command;
    logic [5:0] cell_col;
    logic [5:0] cell_row;
    logic       alive;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       line_end;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  offs;
    logic [11:0] idx;
  } cnt_t;

  typedef struct packed {
    logic wr_en;
    logic wr_data;
    logic rd_en;
  } mem_ctrl_t;

endpackage

[rtl/cgpr_grid_mem.sv]
// Single-bit cell store of the renderer with a clearing sweep after reset.
// Depends on cgpr_pkg for the control struct.
`timescale 1ns / 1ps

module cgpr_grid_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cgpr_pkg::mem_ctrl_t ctrl_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic              rd_data_o,
  output logic              clearing_o
);
  import cgpr_pkg::*;

  logic          mem_q [DEPTH];
  logic          clr_active_q, clr_active_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic          rd_data_q;

  always_comb begin
    clr_active_d = clr_active_q;
    clr_addr_d   = clr_addr_q;
    if (clr_active_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_addr_q   <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_active_q) begin
      mem_q[clr_addr_q] <= 1'b0;
    end else if (ctrl_i.wr_en) begin
      mem_q[wr_addr_i] <= ctrl_i.wr_data;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clr_active_q;

endmodule

[rtl/cell_grid_pixel_renderer_core.sv]
// Top level of the cell grid pixel renderer: counters, pixel pipeline and output register.
// Depends on cgpr_pkg, cgpr_grid_mem and cell_grid_pixel_renderer_core_assert.svh.
`timescale 1ns / 1ps

// The block takes one transaction per clock: a write stores one cell bit, a pixel
// transaction returns the next raster pixel through the stage-one register and an output register,
// so input and output are decoupled by one stage. After reset the cell store is cleared
// one entry per cycle across all GRID_COLS * GRID_ROWS entries (4096 by default); the
// input is stalled during that sweep, and otherwise only when both pipeline stages hold
// a pixel and the output is stalled. Configuration takes effect on the next pixel.

`include "cell_grid_pixel_renderer_core_assert.svh"

module cell_grid_pixel_renderer_core #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  cgpr_pkg::in_item_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output cgpr_pkg::out_item_t              out_data_o,
  input  logic                             cfg_we_i,
  input  logic [cgpr_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [cgpr_pkg::CfgDataW-1:0]    cfg_data_i
);
  import cgpr_pkg::*;

  localparam int unsigned Depth = GRID_COLS * GRID_ROWS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  function automatic cnt_t advance(cnt_t c, logic [7:0] cs);
    cnt_t       res;
    logic [8:0] nxt;
    nxt = {1'b0, c.offs} + 9'd1;
    if (nxt >= ({1'b0, cs} + 9'd1)) begin
      res.offs = '0;
      res.idx  = c.idx + 12'd1;
    end else begin
      res.offs = nxt[7:0];
      res.idx  = c.idx;
    end
    return res;
  endfunction

  logic [11:0] width_q, height_q;
  logic [10:0] margin_x_q, margin_y_q;
  logic [7:0]  cell_size_q;

  logic [11:0] px_q, px_d, py_q, py_d;
  cnt_t        cx_q, cx_d, cy_q, cy_d;

  logic        s1_valid_q, s1_valid_d;
  pix_class_e  s1_class_q;
  logic        s1_in_grid_q, s1_line_end_q, s1_frame_end_q;

  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic        clearing, rd_bit;
  logic        in_acc, pix_acc, s1_move;
  logic        x_before, y_before, in_window, in_grid;
  logic        line_end_c, frame_end_c;
  cnt_t        cx_eff, cy_eff;
  pix_class_e  class_c;
  logic [AW-1:0] wr_addr, rd_addr;
  mem_ctrl_t   mem_ctrl;

  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clearing || (s1_valid_q && !s1_move);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pix_acc    = in_acc && (in_data_i.command == CMD_PIXEL);

  always_comb begin
    x_before  = px_q < {1'b0, margin_x_q};
    y_before  = py_q < {1'b0, margin_y_q};
    cx_eff    = x_before ? '0 : cx_q;
    cy_eff    = y_before ? '0 : cy_q;
    in_window = !x_before && !y_before
             && (({1'b0, px_q} + {2'b0, margin_x_q}) <= {1'b0, width_q})
             && (({1'b0, py_q} + {2'b0, margin_y_q}) <= {1'b0, height_q});
    line_end_c  = ({1'b0, px_q} + 13'd1) >= {1'b0, width_q};
    frame_end_c = line_end_c && (({1'b0, py_q} + 13'd1) >= {1'b0, height_q});
    in_grid     = (int'(cx_eff.idx) < GRID_COLS) && (int'(cy_eff.idx) < GRID_ROWS);
    if (!in_window) begin
      class_c = PIX_BLACK;
    end else if (cx_eff.offs == '0 || cy_eff.offs == '0) begin
      class_c = PIX_LINE;
    end else begin
      class_c = PIX_CELL;
    end
    rd_addr = in_grid ? AW'(int'(cy_eff.idx) * GRID_COLS + int'(cx_eff.idx)) : '0;
    wr_addr = AW'(int'(in_data_i.cell_row) * GRID_COLS + int'(in_data_i.cell_col));
    mem_ctrl.wr_en   = in_acc && (in_data_i.command == CMD_WRITE)
                    && (int'(in_data_i.cell_col) < GRID_COLS)
                    && (int'(in_data_i.cell_row) < GRID_ROWS);
    mem_ctrl.wr_data = in_data_i.alive;
    mem_ctrl.rd_en   = pix_acc;
  end

  always_comb begin
    px_d = px_q;
    py_d = py_q;
    cx_d = cx_q;
    cy_d = cy_q;
    if (pix_acc) begin
      cx_d = cx_eff;
      cy_d = cy_eff;
      if (line_end_c) begin
        px_d = '0;
        cx_d = '0;
        if (frame_end_c) begin
          py_d = '0;
          cy_d = '0;
        end else begin
          if (!y_before) begin
            cy_d = advance(cy_eff, cell_size_q);
          end
          py_d = py_q + 12'd1;
        end
      end else begin
        if (!x_before) begin
          cx_d = advance(cx_eff, cell_size_q);
        end
        px_d = px_q + 12'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= 12'd640;
      height_q    <= 12'd480;
      margin_x_q  <= '0;
      margin_y_q  <= '0;
      cell_size_q <= 8'd8;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH_PIXELS:  width_q     <= cfg_data_i;
        CFG_HEIGHT_PIXELS: height_q    <= cfg_data_i;
        CFG_MARGIN_X:      margin_x_q  <= cfg_data_i[10:0];
        CFG_MARGIN_Y:      margin_y_q  <= cfg_data_i[10:0];
        CFG_CELL_SIZE:     cell_size_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0;
      py_q <= '0;
      cx_q <= '0;
      cy_q <= '0;
    end else begin
      px_q <= px_d;
      py_q <= py_d;
      cx_q <= cx_d;
      cy_q <= cy_d;
    end
  end

  cgpr_grid_mem #(
    .DEPTH (Depth),
    .AW    (AW)
  ) u_grid_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (mem_ctrl),
    .wr_addr_i  (wr_addr),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_bit),
    .clearing_o (clearing)
  );

  assign s1_valid_d  = pix_acc || (s1_valid_q && !s1_move);
  assign out_valid_d = s1_move || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_class_q     <= class_c;
      s1_in_grid_q   <= in_grid;
      s1_line_end_q  <= line_end_c;
      s1_frame_end_q <= frame_end_c;
    end
  end

  always_comb begin
    out_d.line_end  = s1_line_end_q;
    out_d.frame_end = s1_frame_end_q;
    case (s1_class_q)
      PIX_LINE: begin
        out_d.red   = ColorLine;
        out_d.green = ColorLine;
        out_d.blue  = ColorLine;
      end
      PIX_CELL: begin
        if (s1_in_grid_q && rd_bit) begin
          out_d.red   = LiveRed;
          out_d.green = LiveGreen;
          out_d.blue  = LiveBlue;
        end else begin
          out_d.red   = ColorDead;
          out_d.green = ColorDead;
          out_d.blue  = ColorDead;
        end
      end
      default: begin
        out_d.red   = '0;
        out_d.green = '0;
        out_d.blue  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CGPR_ASSERT_SAME(a_frame_end_on_line_end, clk_i, rst_ni, out_valid_o, (!out_data_o.frame_end || out_data_o.line_end))
  `CGPR_ASSERT_NEXT(a_stage_holds_on_stall, clk_i, rst_ni, (s1_valid_q && out_valid_q && out_stall_i), s1_valid_q)
  `CGPR_ASSERT_NEXT(a_frame_wraps_counters, clk_i, rst_ni, (pix_acc && frame_end_c), (px_q == '0 && py_q == '0 && cy_q == '0))
  `CGPR_ASSERT_SAME(a_no_pixel_while_clearing, clk_i, rst_ni, clearing, (!s1_valid_q && !out_valid_q))

endmodule

[test/cell_grid_pixel_renderer_core_tb.sv]
// Self-checking testbench for the cell grid pixel renderer core: cell writes and raster pixels.
// Predicts every pixel with its own copy of the grid, counters and registers; needs cgpr_pkg.
// Runs directed corner frames, then random frames under four idle and stall mixes.
`timescale 1ns / 1ps

module cell_grid_pixel_renderer_core_tb;
  import cgpr_pkg::*;

  localparam int GridCols = 64;
  localparam int GridRows = 64;
  localparam int DrainCycles = 8;
  localparam int CycleLimit = 200000;
  localparam int ReportLimit = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  cell_grid_pixel_renderer_core #(
    .GRID_COLS(GridCols),
    .GRID_ROWS(GridRows)
  ) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  bit cell_map [GridCols*GridRows];
  logic [11:0] raster_x = '0;
  logic [11:0] raster_y = '0;
  logic [7:0] offs_x = '0;
  logic [7:0] offs_y = '0;
  logic [11:0] cell_x = '0;
  logic [11:0] cell_y = '0;
  logic [11:0] frame_width = 12'd640;
  logic [11:0] frame_height = 12'd480;
  logic [10:0] margin_x = '0;
  logic [10:0] margin_y = '0;
  logic [7:0] cfg_cell_size = 8'd8;

  out_item_t expected_pixels[$];
  out_item_t last_pixel;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int items_sent = 0;
  int settings_used = 0;
  int pixels_checked = 0;
  int live_pixels = 0;
  int line_ends = 0;
  int frame_ends = 0;

  function automatic void step_counter(inout logic [7:0] offs, inout logic [11:0] idx);
    int nxt;
    nxt = int'(offs) + 1;
    if (nxt >= int'(cfg_cell_size) + 1) begin
      offs = '0;
      idx = idx + 12'd1;
    end else begin
      offs = nxt[7:0];
    end
  endfunction

  function automatic void store_cell(in_item_t item);
    if (int'(item.cell_col) < GridCols && int'(item.cell_row) < GridRows) begin
      cell_map[int'(item.cell_row) * GridCols + int'(item.cell_col)] = item.alive;
    end
  endfunction

  function automatic out_item_t render_pixel();
    int x, y, w, h, mx, my;
    logic live;
    out_item_t px;
    x = int'(raster_x);
    y = int'(raster_y);
    w = int'(frame_width);
    h = int'(frame_height);
    mx = int'(margin_x);
    my = int'(margin_y);
    if (x < mx) begin
      offs_x = '0;
      cell_x = '0;
    end
    if (y < my) begin
      offs_y = '0;
      cell_y = '0;
    end
    px = '0;
    if (x >= mx && x <= w - mx && y >= my && y <= h - my) begin
      if (offs_x == 8'd0 || offs_y == 8'd0) begin
        px.red = ColorLine;
        px.green = ColorLine;
        px.blue = ColorLine;
      end else begin
        live = 1'b0;
        if (int'(cell_x) < GridCols && int'(cell_y) < GridRows) begin
          live = cell_map[int'(cell_y) * GridCols + int'(cell_x)];
        end
        if (live) begin
          px.red = LiveRed;
          px.green = LiveGreen;
          px.blue = LiveBlue;
        end else begin
          px.red = ColorDead;
          px.green = ColorDead;
          px.blue = ColorDead;
        end
      end
    end
    px.line_end = (x >= w - 1);
    px.frame_end = px.line_end && (y >= h - 1);
    if (px.line_end) begin
      raster_x = '0;
      offs_x = '0;
      cell_x = '0;
      if (px.frame_end) begin
        raster_y = '0;
        offs_y = '0;
        cell_y = '0;
      end else begin
        if (y >= my) step_counter(offs_y, cell_y);
        raster_y = raster_y + 12'd1;
      end
    end else begin
      if (x >= mx) step_counter(offs_x, cell_x);
      raster_x = raster_x + 12'd1;
    end
    return px;
  endfunction

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d pixels outstanding.", cycle_count,
               expected_pixels.size());
      $display("FAIL cell_grid_pixel_renderer_core");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        if (mismatches < ReportLimit) begin
          $display("Unexpected pixel transaction: %p", out_data_o);
        end
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (want.blue == LiveBlue) live_pixels++;
        if (want.line_end) line_ends++;
        if (want.frame_end) frame_ends++;
        if (out_data_o.red !== want.red || out_data_o.green !== want.green ||
            out_data_o.blue !== want.blue || out_data_o.line_end !== want.line_end ||
            out_data_o.frame_end !== want.frame_end) begin
          if (mismatches < ReportLimit) begin
            $display("Pixel %0d mismatch: expected %p, got %p", pixels_checked, want,
                     out_data_o);
          end
          mismatches++;
        end
      end
    end
  end

  task automatic send_item(in_item_t item);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (item.command == CMD_PIXEL) begin
      last_pixel = render_pixel();
      expected_pixels.push_back(last_pixel);
    end else begin
      store_cell(item);
    end
  endtask

  task automatic send_pixels(int count);
    in_item_t item;
    repeat (count) begin
      item.command = CMD_PIXEL;
      item.cell_col = 6'($urandom_range(63));
      item.cell_row = 6'($urandom_range(63));
      item.alive = 1'($urandom_range(1));
      send_item(item);
    end
  endtask

  task automatic send_write(logic [5:0] col, logic [5:0] row, logic alive);
    in_item_t item;
    item.command = CMD_WRITE;
    item.cell_col = col;
    item.cell_row = row;
    item.alive = alive;
    send_item(item);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    case (idx)
      CFG_WIDTH_PIXELS: frame_width = value;
      CFG_HEIGHT_PIXELS: frame_height = value;
      CFG_MARGIN_X: margin_x = value[10:0];
      CFG_MARGIN_Y: margin_y = value[10:0];
      CFG_CELL_SIZE: cfg_cell_size = value[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_frame(int w, int h, int mx, int my, int cs);
    wait_drained();
    write_reg(CFG_WIDTH_PIXELS, CfgDataW'(w));
    write_reg(CFG_HEIGHT_PIXELS, CfgDataW'(h));
    write_reg(CFG_MARGIN_X, CfgDataW'(mx));
    write_reg(CFG_MARGIN_Y, CfgDataW'(my));
    write_reg(CFG_CELL_SIZE, CfgDataW'(cs));
    settings_used++;
  endtask

  task automatic test_reset_defaults();
    send_pixels(3);
  endtask

  task automatic test_extremes();
    set_frame(4095, 4095, 2047, 2047, 255);
    send_pixels(2);
    set_frame(4095, 4095, 0, 0, 255);
    send_write(6'd63, 6'd63, 1'b1);
    send_write(6'd0, 6'd0, 1'b1);
    send_pixels(1);
    set_frame(0, 0, 0, 0, 0);
    send_pixels(3);
    set_frame(3, 2, 0, 0, 1);
    send_pixels(6);
    set_frame(6, 4, 1, 1, 1);
    send_write(6'd0, 6'd0, 1'b0);
    send_pixels(8);
  endtask

  task automatic test_beyond_grid();
    set_frame(136, 2, 0, 0, 1);
    send_write(6'd63, 6'd0, 1'b1);
    send_write(6'd62, 6'd0, 1'b0);
    send_write(6'd0, 6'd0, 1'b1);
    do send_pixels(1); while (!last_pixel.frame_end);
    send_pixels(2 * 136);
  endtask

  task automatic test_random_frames(int idle, int stall, int budget);
    int sent;
    int w, h, cs;
    int runs;
    idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < budget) begin
      w = $urandom_range(1, 24);
      h = $urandom_range(0, 10);
      cs = $urandom_range(0, 4);
      if ($urandom_range(9) == 0) w = $urandom_range(0, 4095);
      if ($urandom_range(9) == 0) cs = $urandom_range(0, 255);
      set_frame(w, h, ($urandom_range(2) == 0) ? 0 : $urandom_range(0, w / 3),
                ($urandom_range(2) == 0) ? 0 : $urandom_range(0, h / 3), cs);
      repeat ($urandom_range(2, 8)) begin
        if ($urandom_range(3) == 0) begin
          send_write(6'($urandom_range(63)), 6'($urandom_range(63)),
                     1'($urandom_range(1)));
        end else begin
          send_write(6'($urandom_range(7)), 6'($urandom_range(7)),
                     $urandom_range(3) != 0);
        end
        sent++;
      end
      runs = $urandom_range(15, 60);
      repeat (runs) begin
        if ($urandom_range(9) == 0) begin
          send_write(6'($urandom_range(63)), 6'($urandom_range(63)),
                     1'($urandom_range(1)));
          sent++;
        end
        send_pixels(1);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_extremes();
    test_beyond_grid();
    test_random_frames(0, 0, 100);
    test_random_frames(50, 0, 100);
    test_random_frames(0, 50, 100);
    test_random_frames(6, 6, 100);
    wait_drained();
    $display("Sent %0d transactions under %0d frame settings and four idle and stall mixes.",
             items_sent, settings_used);
    $display("Checked %0d pixels: %0d live cells, %0d line ends, %0d frame ends.",
             pixels_checked, live_pixels, line_ends, frame_ends);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("PASS cell_grid_pixel_renderer_core");
    end else begin
      $display("%0d mismatches, %0d pixels missing.", mismatches, expected_pixels.size());
      $display("FAIL cell_grid_pixel_renderer_core");
    end
    $finish;
  end

endmodule
